FILE: rtl/core/dde_pkg.sv
`default_nettype none
package dde_pkg;

  // Defaults for the top-level parameters
  localparam int COUNT_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  // Fixed-point constants (angles Q2.13, CORDIC vectors Q.30)
  localparam int JUMP_LIMIT  = 10000;
  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int TWO_PI_Q13  = 51472;
  localparam int GAIN_Q30    = 652032874;
  localparam int MAX_ITER    = 24;
  localparam int US_PER_S    = 1000000;
  localparam int ANG_SCALE   = 8000000;   // Q13 to Q16 (x8) times 1e6

  // Configuration registers
  localparam int           CFG_W      = 20;
  localparam int           REG_IDX_W  = 1;
  localparam logic [15:0]  TPM_RESET  = 16'd2270;
  localparam logic [19:0]  WB_RESET   = 20'd14680;

  // Divider sizes
  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = 20;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TPM = 1'b0,
    REG_WB  = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_SET   = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SET,
    OP_CNT,
    OP_STEP_WR,
    OP_PREP,
    OP_LIN_MUL,
    OP_DIV_PROD,
    OP_LIN_WR,
    OP_DIV_ARG,
    OP_ARG_WR,
    OP_CORDIC_T,
    OP_ASIN_CMP,
    OP_BIT_NEXT,
    OP_CORDIC_AVG,
    OP_MUL_X,
    OP_MUL_Y,
    OP_POS_WR,
    OP_ANG_MUL,
    OP_ANG_WR,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    mode_e mode;
    logic  pose_valid;
    logic  cnt_use;
    logic  fault;
    logic  t_ok;
    logic  bit_zero;
    logic  div_done;
    logic  cordic_done;
    logic  out_free;
  } status_t;

  // atan(2^-i), Q.24 radians
  function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
    logic signed [27:0] r;
    case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  // One wrap by 2*pi into plus/minus pi
  function automatic logic signed [15:0] wrap_q13(input logic signed [16:0] a);
    logic signed [17:0] w;
    w = 18'(a);
    if (w > 18'(PI_Q13)) begin
      w = w - 18'(TWO_PI_Q13);
    end else if (w < -18'(PI_Q13)) begin
      w = w + 18'(TWO_PI_Q13);
    end
    return w[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dde_if.sv
`default_nettype none
// Input channel: one item is a count, a pose set or an update tick
interface dde_in_if #(parameter int CountBits = 16);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic signed [CountBits-1:0] count;
  logic signed [31:0]          set_x;
  logic signed [31:0]          set_y;
  logic signed [15:0]          set_heading;
  logic [19:0]                 elapsed_us;

  modport source (output valid, mode, count, set_x, set_y, set_heading, elapsed_us,
                  input ready);
  modport sink   (input valid, mode, count, set_x, set_y, set_heading, elapsed_us,
                  output ready);
endinterface

// Output channel: pose and velocities after a tick
interface dde_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] yaw;
  logic signed [31:0] linear_velocity;
  logic signed [31:0] angular_velocity;
  logic               fault;

  modport source (output valid, pos_x, pos_y, yaw, linear_velocity, angular_velocity,
                  fault, input ready);
  modport sink   (input valid, pos_x, pos_y, yaw, linear_velocity, angular_velocity,
                  fault, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dde_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle; signed, saturated result
module dde_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dde_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [dde_pkg::DIV_DEN_W-1:0]  den_i,
  input  logic                           neg_i,
  output logic                           done_o,
  output logic signed [31:0]             quot_o
);
  import dde_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);

  logic                 busy_q, done_q, neg_q;
  logic [CW-1:0]        cnt_q;
  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_NUM_W-1:0] quo_q;

  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= neg_i;
        cnt_q  <= '0;
        rem_q  <= '0;
        den_q  <= den_i;
        quo_q  <= num_i;
      end else if (busy_q) begin
        rem_q <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
        quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // sign and saturate the magnitude
  always_comb begin
    if (!neg_q) begin
      quot_o = (quo_q > DIV_NUM_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(quo_q[31:0]);
    end else begin
      quot_o = (quo_q > DIV_NUM_W'(33'h080000000)) ? 32'sh80000000
                                                   : $signed(-quo_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: rtl/core/dde_cordic.sv
`default_nettype none
// Iterative rotation CORDIC: cos and sin (Q.30) of a Q2.13 angle
module dde_cordic #(
  parameter int Steps = dde_pkg::CORDIC_STEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import dde_pkg::*;

  localparam int N  = (Steps > MAX_ITER) ? MAX_ITER : Steps;
  localparam int IW = $clog2(N);

  logic               busy_q, done_q, neg_q;
  logic [IW-1:0]      i_q;
  logic signed [33:0] x_q, y_q, cos_q, sin_q;
  logic signed [27:0] z_q;

  logic signed [16:0] a_pre;
  logic               neg_pre;
  logic signed [33:0] xs, ys, nx, ny;
  logic signed [27:0] at, nz;

  // fold into plus/minus pi/2
  always_comb begin
    a_pre   = 17'(angle_i);
    neg_pre = 1'b0;
    if (a_pre > 17'(HALF_PI_Q13)) begin
      a_pre   = a_pre - 17'(PI_Q13);
      neg_pre = 1'b1;
    end else if (a_pre < -17'(HALF_PI_Q13)) begin
      a_pre   = a_pre + 17'(PI_Q13);
      neg_pre = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = atan_q24(5'(i_q));
    if (z_q >= 0) begin
      nx = x_q - ys;
      ny = y_q + xs;
      nz = z_q - at;
    end else begin
      nx = x_q + ys;
      ny = y_q - xs;
      nz = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      i_q    <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      cos_q  <= '0;
      sin_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= neg_pre;
        i_q    <= '0;
        x_q    <= 34'(GAIN_Q30);
        y_q    <= '0;
        z_q    <= 28'(a_pre) <<< 11;
      end else if (busy_q) begin
        x_q <= nx;
        y_q <= ny;
        z_q <= nz;
        i_q <= i_q + 1'b1;
        if (i_q == IW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          cos_q  <= neg_q ? -nx : nx;
          sin_q  <= neg_q ? -ny : ny;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule
`default_nettype wire

FILE: rtl/core/dde_datapath.sv
`default_nettype none
// Odometry datapath: state, configuration, scratch registers, shared units
module dde_datapath #(
  parameter int CountBits   = dde_pkg::COUNT_BITS,
  parameter int CordicSteps = dde_pkg::CORDIC_STEPS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dde_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dde_pkg::CFG_W-1:0]       cfg_data_i,
  dde_in_if.sink                          in_if,
  dde_out_if.source                       out_if,
  input  dde_pkg::cmd_t                   cmd_i,
  output dde_pkg::status_t                status_o
);
  import dde_pkg::*;

  // configuration
  logic [15:0] tpm_q;
  logic [19:0] wb_q;

  // block state
  logic [CountBits-1:0] last_l_q, last_r_q;
  logic signed [31:0]   lstep_q, rstep_q, px_q, py_q;
  logic signed [15:0]   hd_q;
  logic                 pv_q;

  // captured item
  mode_e                mode_q;
  logic [CountBits-1:0] count_q;
  logic signed [31:0]   setx_q, sety_q;
  logic signed [15:0]   seth_q;
  logic [19:0]          e_q;

  // scratch
  logic signed [31:0]   dist_q, lin_q, ang_q;
  logic [20:0]          mag_q;
  logic                 neg_q, fault_q;
  logic signed [52:0]   prod_q;
  logic [30:0]          arg_q;
  logic [13:0]          a_q;
  logic [3:0]           bit_q;
  logic signed [65:0]   pxp_q, pyp_q;

  // output register
  logic                 out_valid_q;
  logic signed [31:0]   ox_q, oy_q, olin_q, oang_q;
  logic signed [15:0]   oyaw_q;
  logic                 ofault_q;

  logic in_fire;
  assign in_fire     = in_if.valid & in_if.ready;
  assign in_if.ready = cmd_i.in_ready;

  // count differencing and unwrap
  logic signed [CountBits-1:0] cur_s, last_s;
  logic signed [33:0]          d_raw, d_unw, span;
  logic [33:0]                 d_mag;
  logic                        cnt_use;
  logic [15:0]                 tpm_eff;
  logic [19:0]                 wb_eff;

  assign cur_s   = count_q;
  assign last_s  = (mode_q == MODE_LEFT) ? last_l_q : last_r_q;
  assign cnt_use = (count_q != '0) && (last_s != '0);
  assign span    = 34'sd1 <<< CountBits;
  assign d_raw   = 34'(cur_s) - 34'(last_s);
  assign tpm_eff = (tpm_q == '0) ? 16'd1 : tpm_q;
  assign wb_eff  = (wb_q == '0) ? 20'd1 : wb_q;

  always_comb begin
    if (d_raw > 34'(JUMP_LIMIT)) begin
      d_unw = d_raw - span;
    end else if (d_raw < -34'(JUMP_LIMIT)) begin
      d_unw = d_raw + span;
    end else begin
      d_unw = d_raw;
    end
    d_mag = (d_unw < 0) ? 34'(-d_unw) : 34'(d_unw);
  end

  // mean step and step difference
  logic signed [32:0] sum33, diff33;
  logic [32:0]        mag33;
  logic signed [31:0] dist32;

  assign sum33  = 33'(lstep_q) + 33'(rstep_q);
  assign diff33 = 33'(rstep_q) - 33'(lstep_q);
  assign mag33  = (diff33 < 0) ? 33'(-diff33) : 33'(diff33);
  assign dist32 = 32'((sum33 + ((sum33 < 0) ? 33'sd1 : 33'sd0)) >>> 1);

  // step angle, halved toward zero
  logic signed [15:0] a_s, ca, half;
  logic [13:0]        t_try;
  logic               t_ok;

  assign a_s   = 16'(a_q);
  assign ca    = neg_q ? -a_s : a_s;
  assign half  = neg_q ? -(a_s >>> 1) : (a_s >>> 1);
  assign t_try = a_q | (14'd1 << bit_q);
  assign t_ok  = t_try <= 14'(HALF_PI_Q13);

  // shared divider
  logic                  div_start, div_neg, div_done;
  logic [DIV_NUM_W-1:0]  div_num, prod_mag;
  logic [DIV_DEN_W-1:0]  div_den;
  logic signed [31:0]    div_q;

  assign prod_mag = (prod_q < 0) ? DIV_NUM_W'(-prod_q) : DIV_NUM_W'(prod_q);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_neg   = 1'b0;
    case (cmd_i.op)
      OP_CNT: begin
        div_start = cnt_use;
        div_num   = DIV_NUM_W'({d_mag, 16'b0});
        div_den   = DIV_DEN_W'(tpm_eff);
        div_neg   = d_unw < 0;
      end
      OP_DIV_PROD: begin
        div_start = 1'b1;
        div_num   = prod_mag;
        div_den   = e_q;
        div_neg   = prod_q < 0;
      end
      OP_DIV_ARG: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({mag_q, 30'b0});
        div_den   = wb_eff;
      end
      default: ;
    endcase
  end

  dde_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .neg_i   (div_neg),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // shared CORDIC
  logic               cor_start, cor_done;
  logic signed [15:0] cor_angle, avg;
  logic signed [33:0] cor_cos, cor_sin;

  assign avg       = wrap_q13(17'(hd_q) + 17'(half));
  assign cor_start = (cmd_i.op == OP_CORDIC_T) || (cmd_i.op == OP_CORDIC_AVG);
  assign cor_angle = (cmd_i.op == OP_CORDIC_T) ? $signed(16'(t_try)) : avg;

  dde_cordic #(.Steps(CordicSteps)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  // multipliers, each registered
  logic signed [33:0] mul_a;
  logic signed [65:0] mul_p;
  logic signed [52:0] lin_p, ang_p;

  assign mul_a = (cmd_i.op == OP_MUL_Y) ? cor_sin : cor_cos;
  assign mul_p = 66'(mul_a) * 66'(dist_q);
  assign lin_p = 53'(dist_q) * 53'(US_PER_S);
  assign ang_p = 53'(ca) * 53'(ANG_SCALE);

  // new position
  logic signed [39:0] xs40, ys40;
  assign xs40 = 40'(px_q) + 40'(pxp_q >>> 30);
  assign ys40 = 40'(py_q) + 40'(pyp_q >>> 30);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= TPM_RESET;
      wb_q  <= WB_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TPM: tpm_q <= cfg_data_i[15:0];
        REG_WB:  wb_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
      lstep_q  <= '0;
      rstep_q  <= '0;
      px_q     <= '0;
      py_q     <= '0;
      hd_q     <= '0;
      pv_q     <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_CNT: begin
          if (mode_q == MODE_LEFT) begin
            last_l_q <= count_q;
          end else begin
            last_r_q <= count_q;
          end
        end
        OP_STEP_WR: begin
          if (mode_q == MODE_LEFT) begin
            lstep_q <= div_q;
          end else begin
            rstep_q <= div_q;
          end
        end
        OP_SET: begin
          px_q <= setx_q;
          py_q <= sety_q;
          hd_q <= wrap_q13(17'(seth_q));
          pv_q <= 1'b1;
        end
        OP_POS_WR: begin
          px_q <= sat32(xs40);
          py_q <= sat32(ys40);
          hd_q <= wrap_q13(17'(hd_q) + 17'(ca));
        end
        default: ;
      endcase
    end
  end

  // item capture and scratch
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= mode_e'(in_if.mode);
      count_q <= in_if.count;
      setx_q  <= in_if.set_x;
      sety_q  <= in_if.set_y;
      seth_q  <= in_if.set_heading;
      e_q     <= (in_if.elapsed_us == '0) ? 20'd1 : in_if.elapsed_us;
    end
    case (cmd_i.op)
      OP_PREP: begin
        dist_q  <= dist32;
        mag_q   <= mag33[20:0];
        neg_q   <= diff33 < 0;
        fault_q <= mag33 > 33'(wb_eff);
        ang_q   <= '0;
      end
      OP_LIN_MUL: prod_q <= lin_p;
      OP_ANG_MUL: prod_q <= ang_p;
      OP_LIN_WR:  lin_q  <= div_q;
      OP_ANG_WR:  ang_q  <= div_q;
      OP_ARG_WR: begin
        arg_q <= div_q[30:0];
        a_q   <= '0;
        bit_q <= 4'd13;
      end
      OP_ASIN_CMP: begin
        if (cor_sin <= $signed({3'b0, arg_q})) begin
          a_q <= t_try;
        end
        bit_q <= bit_q - 1'b1;
      end
      OP_BIT_NEXT: bit_q <= bit_q - 1'b1;
      OP_MUL_X:    pxp_q <= mul_p;
      OP_MUL_Y:    pyp_q <= mul_p;
      OP_OUT: begin
        ox_q     <= px_q;
        oy_q     <= py_q;
        oyaw_q   <= hd_q;
        olin_q   <= lin_q;
        oang_q   <= ang_q;
        ofault_q <= fault_q;
      end
      default: ;
    endcase
  end

  // output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.pos_x            = ox_q;
  assign out_if.pos_y            = oy_q;
  assign out_if.yaw              = oyaw_q;
  assign out_if.linear_velocity  = olin_q;
  assign out_if.angular_velocity = oang_q;
  assign out_if.fault            = ofault_q;

  always_comb begin
    status_o.in_valid    = in_if.valid;
    status_o.mode        = mode_q;
    status_o.pose_valid  = pv_q;
    status_o.cnt_use     = cnt_use;
    status_o.fault       = fault_q;
    status_o.t_ok        = t_ok;
    status_o.bit_zero    = bit_q == '0;
    status_o.div_done    = div_done;
    status_o.cordic_done = cor_done;
    status_o.out_free    = !out_valid_q || out_if.ready;
  end

endmodule
`default_nettype wire

FILE: rtl/core/dde_ctrl.sv
`default_nettype none
// Sequencer: steps the datapath through each kind of item
module dde_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dde_pkg::status_t status_i,
  output dde_pkg::cmd_t    cmd_o
);
  import dde_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CNT,
    S_CNT_WAIT,
    S_PREP,
    S_LIN_MUL,
    S_LIN_DIV,
    S_LIN_WAIT,
    S_ARG_DIV,
    S_ARG_WAIT,
    S_ASIN_TRY,
    S_ASIN_WAIT,
    S_AVG,
    S_AVG_WAIT,
    S_MUL_Y,
    S_POS_WR,
    S_ANG_MUL,
    S_ANG_DIV,
    S_ANG_WAIT,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  op_e    op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (status_i.in_valid && ready_q) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.mode)
          MODE_LEFT, MODE_RIGHT: state_d = S_CNT;
          MODE_SET: begin
            op      = OP_SET;
            state_d = S_IDLE;
          end
          MODE_TICK: state_d = status_i.pose_valid ? S_PREP : S_IDLE;
          default:   state_d = S_IDLE;
        endcase
      end
      S_CNT: begin
        op      = OP_CNT;
        state_d = status_i.cnt_use ? S_CNT_WAIT : S_IDLE;
      end
      S_CNT_WAIT: begin
        if (status_i.div_done) begin
          op      = OP_STEP_WR;
          state_d = S_IDLE;
        end
      end
      S_PREP: begin
        op      = OP_PREP;
        state_d = S_LIN_MUL;
      end
      S_LIN_MUL: begin
        op      = OP_LIN_MUL;
        state_d = S_LIN_DIV;
      end
      S_LIN_DIV: begin
        op      = OP_DIV_PROD;
        state_d = S_LIN_WAIT;
      end
      S_LIN_WAIT: begin
        if (status_i.div_done) begin
          op      = OP_LIN_WR;
          state_d = status_i.fault ? S_OUT : S_ARG_DIV;
        end
      end
      S_ARG_DIV: begin
        op      = OP_DIV_ARG;
        state_d = S_ARG_WAIT;
      end
      S_ARG_WAIT: begin
        if (status_i.div_done) begin
          op      = OP_ARG_WR;
          state_d = S_ASIN_TRY;
        end
      end
      // bitwise asin search, most significant bit first
      S_ASIN_TRY: begin
        if (status_i.t_ok) begin
          op      = OP_CORDIC_T;
          state_d = S_ASIN_WAIT;
        end else begin
          op      = OP_BIT_NEXT;
          state_d = status_i.bit_zero ? S_AVG : S_ASIN_TRY;
        end
      end
      S_ASIN_WAIT: begin
        if (status_i.cordic_done) begin
          op      = OP_ASIN_CMP;
          state_d = status_i.bit_zero ? S_AVG : S_ASIN_TRY;
        end
      end
      S_AVG: begin
        op      = OP_CORDIC_AVG;
        state_d = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (status_i.cordic_done) begin
          op      = OP_MUL_X;
          state_d = S_MUL_Y;
        end
      end
      S_MUL_Y: begin
        op      = OP_MUL_Y;
        state_d = S_POS_WR;
      end
      S_POS_WR: begin
        op      = OP_POS_WR;
        state_d = S_ANG_MUL;
      end
      S_ANG_MUL: begin
        op      = OP_ANG_MUL;
        state_d = S_ANG_DIV;
      end
      S_ANG_DIV: begin
        op      = OP_DIV_PROD;
        state_d = S_ANG_WAIT;
      end
      S_ANG_WAIT: begin
        if (status_i.div_done) begin
          op      = OP_ANG_WR;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          op      = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= state_d == S_IDLE;
    end
  end

  assign cmd_o.op       = op;
  assign cmd_o.in_ready = ready_q;

endmodule
`default_nettype wire

FILE: rtl/core/diff_drive_encoder_odometry_top.sv
// A count item runs the shared divider unless the new or last count is zero; a tick takes
// 3 divisions (one on a fault) plus a 14-pass asin search, each pass at most one CORDIC run.
// One item is worked at a time; a finished result waits in an output register.
// Reset (async, active low) clears pose, steps and last counts and loads the
// register defaults; no clearing pass.
`default_nettype none
module diff_drive_encoder_odometry_top #(
  parameter int CountBits   = dde_pkg::COUNT_BITS,
  parameter int CordicSteps = dde_pkg::CORDIC_STEPS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dde_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [dde_pkg::CFG_W-1:0]     cfg_data_i,
  dde_in_if.sink                        in_if,
  dde_out_if.source                     out_if
);
  import dde_pkg::*;

  cmd_t    cmd;
  status_t status;

  dde_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dde_datapath #(
    .CountBits   (CountBits),
    .CordicSteps (CordicSteps)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule
`default_nettype wire
